/* rtl/core/dcsp_pkg.sv */
package dcsp_pkg;

    // Width of the tick counter and of the window length register.
    localparam int WINDOW_WIDTH = 10;

    // High-sample counters hold one more bit than the tick counter.
    localparam int CNT_W  = WINDOW_WIDTH + 1;
    localparam int IN_W   = 11;
    localparam int OUT_W  = 16;
    localparam int DIFF_W = (CNT_W > IN_W) ? CNT_W : IN_W;
    localparam int PROD_W = DIFF_W + OUT_W;
    localparam int ALU_W  = PROD_W + 1;
    localparam int STEP_W = $clog2(PROD_W + 1);

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // Register indexes on the configuration port.
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_TICKS = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IN_LOW       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_IN_HIGH      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_OUT_LOW      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_OUT_HIGH     = 3'd4;

    localparam logic [WINDOW_WIDTH-1:0] WINDOW_RST   = WINDOW_WIDTH'(100);
    localparam logic [IN_W-1:0]         IN_LOW_RST   = 11'd36;
    localparam logic [IN_W-1:0]         IN_HIGH_RST  = 11'd64;
    localparam logic [OUT_W-1:0]        OUT_LOW_RST  = 16'd32500;
    localparam logic [OUT_W-1:0]        OUT_HIGH_RST = 16'd42500;

    localparam logic AXIS_Y = 1'b0;
    localparam logic AXIS_X = 1'b1;

    typedef struct packed {
        logic x_level;
        logic y_level;
    } t_in;

    typedef struct packed {
        logic             servo_axis;
        logic [OUT_W-1:0] pulse_width;
    } t_out;

endpackage

/* rtl/core/duty_count_to_servo_pulse.sv */
// Duty-count to servo pulse width converter.
//
// Each request on the input channel is one sample tick carrying the sampled
// levels of the X and Y accelerometer PWM pins. The block counts high samples
// per axis and counts ticks. On the tick where the tick count has reached
// window_ticks, the window closes: one axis count (Y first, then alternating)
// is mapped linearly from [in_low, in_high] onto [out_low, out_high], and a
// single request carrying the axis and the saturated pulse width is issued on
// the output channel. Ticks that do not close a window produce nothing.
//
// A tick that does not close a window is accepted while the block is idle, and
// the next may follow at once. A closing tick starts the shared add/subtract
// unit: a shift-add multiply, a restoring divide and a final step that adds the
// quotient to out_low, or subtracts it, and saturates; an empty input range
// skips straight to the final step. Input ready stays low while the sequencer
// runs, and longer while a finished result waits.
// The result sits in an output register; while the receiver stalls, further
// non-closing ticks are still accepted, and only a new result waits for it.
// Reset (synchronous, active low) clears the counters, restores the register
// defaults and empties the output register.
module duty_count_to_servo_pulse (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  dcsp_pkg::t_in                     i_in_data,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output dcsp_pkg::t_out                    o_out_data,
    input  logic                              i_cfg_wr_en,
    input  logic [dcsp_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [dcsp_pkg::CFG_DATA_W-1:0]   i_cfg_wr_data
);
    import dcsp_pkg::*;

    // Sequencer states.
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_MUL  = 2'd1;
    localparam logic [1:0] S_DIV  = 2'd2;
    localparam logic [1:0] S_FIN  = 2'd3;

    // Configuration registers.
    logic [WINDOW_WIDTH-1:0] r_window_ticks;
    logic [IN_W-1:0]         r_in_low;
    logic [IN_W-1:0]         r_in_high;
    logic [OUT_W-1:0]        r_out_low;
    logic [OUT_W-1:0]        r_out_high;

    // Measurement state.
    logic [WINDOW_WIDTH-1:0] r_tick_count;
    logic [CNT_W-1:0]        r_x_count;
    logic [CNT_W-1:0]        r_y_count;
    logic                    r_next_axis;

    // Arithmetic sequencer state.
    logic [1:0]        r_state;
    logic [STEP_W-1:0] r_step;
    logic [PROD_W-1:0] r_acc;      // product, then dividend and quotient
    logic [DIFF_W-1:0] r_mplier;
    logic [OUT_W-1:0]  r_mcand;
    logic [IN_W-1:0]   r_divisor;
    logic [IN_W-1:0]   r_rem;
    logic              r_neg;
    logic              r_axis;

    // Output register.
    logic r_out_valid;
    t_out r_out_data;

    logic             in_fire;
    logic             out_free;
    logic [CNT_W-1:0] x_bumped;
    logic [CNT_W-1:0] y_bumped;
    logic [CNT_W-1:0] sel_count;
    logic [DIFF_W-1:0] count_ext;
    logic [DIFF_W-1:0] low_ext;
    logic              close_win;
    logic              empty_range;

    logic [ALU_W-1:0] alu_a;
    logic [ALU_W-1:0] alu_b;
    logic             alu_sub;
    logic [ALU_W-1:0] alu_res;
    logic [OUT_W-1:0] sat_res;

    assign o_in_ready  = (r_state == S_IDLE);
    assign in_fire     = i_in_valid && o_in_ready;
    assign out_free    = !r_out_valid || i_out_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    // High counts saturate at their maximum instead of wrapping. The closing
    // tick's samples count toward the window being mapped.
    assign x_bumped = (i_in_data.x_level && !(&r_x_count)) ? r_x_count + 1'b1 : r_x_count;
    assign y_bumped = (i_in_data.y_level && !(&r_y_count)) ? r_y_count + 1'b1 : r_y_count;
    assign sel_count   = (r_next_axis == AXIS_X) ? x_bumped : y_bumped;
    assign count_ext   = DIFF_W'(sel_count);
    assign low_ext     = DIFF_W'(r_in_low);
    assign close_win   = (r_tick_count >= r_window_ticks);
    assign empty_range = (r_in_high <= r_in_low);

    // The one shared adder/subtractor. It accumulates partial products during
    // the multiply, forms the trial remainder during the divide, and adds or
    // subtracts the quotient from out_low at the end.
    always_comb begin
        alu_a   = '0;
        alu_b   = '0;
        alu_sub = 1'b0;
        case (r_state)
            S_MUL: begin
                alu_a = ALU_W'({r_acc[PROD_W-2:0], 1'b0});
                alu_b = r_mplier[DIFF_W-1] ? ALU_W'(r_mcand) : '0;
            end
            S_DIV: begin
                alu_a   = ALU_W'({r_rem, r_acc[PROD_W-1]});
                alu_b   = ALU_W'(r_divisor);
                alu_sub = 1'b1;
            end
            S_FIN: begin
                alu_a   = ALU_W'(r_out_low);
                alu_b   = ALU_W'(r_acc);
                alu_sub = r_neg;
            end
            default: begin
                alu_sub = 1'b0;
            end
        endcase
    end

    assign alu_res = alu_sub ? (alu_a - alu_b) : (alu_a + alu_b);

    // Clamp the final sum into the 16-bit pulse range.
    always_comb begin
        if (alu_res[ALU_W-1]) begin
            sat_res = '0;
        end else if (|alu_res[ALU_W-2:OUT_W]) begin
            sat_res = '1;
        end else begin
            sat_res = alu_res[OUT_W-1:0];
        end
    end

    // Configuration port.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_ticks <= WINDOW_RST;
            r_in_low       <= IN_LOW_RST;
            r_in_high      <= IN_HIGH_RST;
            r_out_low      <= OUT_LOW_RST;
            r_out_high     <= OUT_HIGH_RST;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                CFG_WINDOW_TICKS: r_window_ticks <= i_cfg_wr_data[WINDOW_WIDTH-1:0];
                CFG_IN_LOW:       r_in_low       <= i_cfg_wr_data[IN_W-1:0];
                CFG_IN_HIGH:      r_in_high      <= i_cfg_wr_data[IN_W-1:0];
                CFG_OUT_LOW:      r_out_low      <= i_cfg_wr_data[OUT_W-1:0];
                CFG_OUT_HIGH:     r_out_high     <= i_cfg_wr_data[OUT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Control: counters, sequencer and output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick_count <= '0;
            r_x_count    <= '0;
            r_y_count    <= '0;
            r_next_axis  <= AXIS_Y;
            r_state      <= S_IDLE;
            r_step       <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (r_state == S_FIN && out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_fire) begin
                        if (close_win) begin
                            r_tick_count <= '0;
                            r_x_count    <= '0;
                            r_y_count    <= '0;
                            r_next_axis  <= ~r_next_axis;
                            r_step       <= '0;
                            r_state      <= empty_range ? S_FIN : S_MUL;
                        end else begin
                            r_tick_count <= r_tick_count + 1'b1;
                            r_x_count    <= x_bumped;
                            r_y_count    <= y_bumped;
                        end
                    end
                end
                S_MUL: begin
                    if (r_step == STEP_W'(DIFF_W - 1)) begin
                        r_step  <= '0;
                        r_state <= S_DIV;
                    end else begin
                        r_step <= r_step + 1'b1;
                    end
                end
                S_DIV: begin
                    if (r_step == STEP_W'(PROD_W - 1)) begin
                        r_step  <= '0;
                        r_state <= S_FIN;
                    end else begin
                        r_step <= r_step + 1'b1;
                    end
                end
                S_FIN: begin
                    // The sum stays valid while the result waits for room.
                    if (out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (in_fire && close_win) begin
                    r_axis <= r_next_axis;
                    r_acc  <= '0;
                    r_rem  <= '0;
                    // A count below in_low is clamped to it.
                    r_mplier  <= (count_ext > low_ext) ? count_ext - low_ext : '0;
                    r_divisor <= r_in_high - r_in_low;
                    if (empty_range) begin
                        r_neg <= 1'b0;
                    end else begin
                        // Falling output range: divide magnitudes, then subtract,
                        // so the quotient truncates toward zero.
                        r_neg   <= (r_out_high < r_out_low);
                        r_mcand <= (r_out_high < r_out_low) ? r_out_low - r_out_high
                                                            : r_out_high - r_out_low;
                    end
                end
            end
            S_MUL: begin
                r_acc    <= alu_res[PROD_W-1:0];
                r_mplier <= {r_mplier[DIFF_W-2:0], 1'b0};
            end
            S_DIV: begin
                if (!alu_res[ALU_W-1]) begin
                    r_rem <= alu_res[IN_W-1:0];
                    r_acc <= {r_acc[PROD_W-2:0], 1'b1};
                end else begin
                    r_rem <= {r_rem[IN_W-2:0], r_acc[PROD_W-1]};
                    r_acc <= {r_acc[PROD_W-2:0], 1'b0};
                end
            end
            S_FIN: begin
                if (out_free) begin
                    r_out_data.servo_axis  <= r_axis;
                    r_out_data.pulse_width <= sat_res;
                end
            end
            default: begin
            end
        endcase
    end

endmodule
